@@ rtl/rdc_pkg.sv @@
// ============================================================================
// rdc_pkg
// Shared types, constants and helpers for the radix digit converter.
// ============================================================================
`default_nettype none

package rdc_pkg;

  localparam int DIGIT_W    = 6;    // one digit, 0..35
  localparam int CHAR_W     = 7;    // ASCII character
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;

  localparam int DEF_MAX_DIGITS = 32;
  localparam int DEF_VALUE_BITS = 31;

  localparam logic [DIGIT_W-1:0] BASE_MIN   = 6'd2;
  localparam logic [DIGIT_W-1:0] BASE_MAX   = 6'd36;
  localparam logic [DIGIT_W-1:0] BASE_RESET = 6'd10;
  localparam logic [DIGIT_W-1:0] DEC_LIMIT  = 6'd10;

  localparam logic [CHAR_W-1:0] CHAR_ZERO = 7'h30;  // '0'
  localparam logic [CHAR_W-1:0] CHAR_A    = 7'h41;  // 'A'

  // register index of target_base
  localparam logic REG_TARGET_BASE = 1'b0;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_READ = 4'b0100,
    ST_SHOW = 4'b1000
  } state_t;

  function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] v);
    logic [CHAR_W-1:0] vx;
    vx = {1'b0, v};
    if (v < DEC_LIMIT) begin
      return CHAR_ZERO + vx;
    end
    return CHAR_A + vx - {1'b0, DEC_LIMIT};
  endfunction

endpackage

`default_nettype wire

@@ rtl/rdc_divider.sv @@
// ============================================================================
// rdc_divider
// Bit-serial restoring divider: one quotient bit per cycle by a 6-bit base.
// ============================================================================
`default_nettype none

module rdc_divider #(
  parameter int VALUE_BITS = rdc_pkg::DEF_VALUE_BITS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [VALUE_BITS-1:0]       dividend,
  input  logic [rdc_pkg::DIGIT_W-1:0] base,
  output logic                        done,
  output logic [VALUE_BITS-1:0]       quot,
  output logic [rdc_pkg::DIGIT_W-1:0] rem
);
  import rdc_pkg::*;

  localparam int CW = $clog2(VALUE_BITS + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [DIGIT_W:0] trial;
  logic [DIGIT_W:0] diff;
  logic          ge;

  // partial remainder with the next dividend bit shifted in
  assign trial = {rem, quot[VALUE_BITS-1]};
  assign ge    = trial >= {1'b0, base};
  assign diff  = trial - {1'b0, base};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(VALUE_BITS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot <= dividend;
      rem  <= '0;
    end else if (busy) begin
      quot <= {quot[VALUE_BITS-2:0], ge};
      rem  <= ge ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
    end
  end

endmodule

`default_nettype wire

@@ rtl/rdc_digit_store.sv @@
// ============================================================================
// rdc_digit_store
// Digit memory: one write port, one read port with registered data.
// ============================================================================
`default_nettype none

module rdc_digit_store #(
  parameter int DEPTH = rdc_pkg::DEF_MAX_DIGITS,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [AW-1:0]               waddr,
  input  logic [rdc_pkg::DIGIT_W-1:0] wdata,
  input  logic                        re,
  input  logic [AW-1:0]               raddr,
  output logic [rdc_pkg::DIGIT_W-1:0] rdata
);
  import rdc_pkg::*;

  logic [DIGIT_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/radix_digit_converter.sv @@
// ============================================================================
// radix_digit_converter
// Converts an unsigned integer to base 2..36 digits, most significant first.
// ============================================================================
// Sequence: each digit is one division in the bit-serial divider
//   (load plus one quotient bit per cycle); after the last division the
//   most significant digit is read from the digit memory, then loaded into
//   the output register. Zero skips the divider: its digit is written on
//   accept and takes the same read path. One number at a time: the next one
//   is taken once the last digit is in the output register.
// Reset: synchronous, active high; base returns to 10, output empties.
`default_nettype none

module radix_digit_converter #(
  parameter int MAX_DIGITS = rdc_pkg::DEF_MAX_DIGITS,
  parameter int VALUE_BITS = rdc_pkg::DEF_VALUE_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  // input stream
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [((VALUE_BITS+7)/8)*8-1:0]     s_tdata,   // [VALUE_BITS-1:0] number_value
  // output stream
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [15:0]                         m_tdata,   // [5:0] digit_value, [12:6] digit_char
  output logic                                m_tlast,   // last_digit
  // configuration
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [rdc_pkg::CFG_ADDR_W-1:0]      paddr,
  input  logic [rdc_pkg::CFG_DATA_W-1:0]      pwdata,
  output logic [rdc_pkg::CFG_DATA_W-1:0]      prdata,
  output logic                                pready
);
  import rdc_pkg::*;

  localparam int AW    = $clog2(MAX_DIGITS);
  localparam int CNT_W = $clog2(MAX_DIGITS + 1);

  state_t state;

  logic [DIGIT_W-1:0] base;
  logic [CNT_W-1:0]   count;     // digits stored so far
  logic [AW-1:0]      rd_idx;    // next digit to show, counts down

  // divider
  logic                  div_start;
  logic [VALUE_BITS-1:0] div_dividend;
  logic                  div_done;
  logic [VALUE_BITS-1:0] div_quot;
  logic [DIGIT_W-1:0]    div_rem;

  // digit memory
  logic               st_we;
  logic [AW-1:0]      st_waddr;
  logic [DIGIT_W-1:0] st_wdata;
  logic               st_re;
  logic [AW-1:0]      st_raddr;
  logic [DIGIT_W-1:0] st_rdata;

  logic               accept;
  logic               in_zero;
  logic               out_load;
  logic               cfg_wr;
  logic [DIGIT_W-1:0] cfg_val;
  logic [DIGIT_W-1:0] out_value;
  logic               out_last;

  // ---------------------------------------------------------------------------
  // Configuration: out-of-range bases are dropped, register keeps old value.
  // ---------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready && (paddr[2] == REG_TARGET_BASE);
  assign cfg_val = pwdata[DIGIT_W-1:0];
  assign prdata  = CFG_DATA_W'(base);

  always_ff @(posedge clk) begin
    if (rst) begin
      base <= BASE_RESET;
    end else if (cfg_wr && cfg_val >= BASE_MIN && cfg_val <= BASE_MAX) begin
      base <= cfg_val;
    end
  end

  // ---------------------------------------------------------------------------
  // Control
  // ---------------------------------------------------------------------------
  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign in_zero  = (s_tdata[VALUE_BITS-1:0] == '0);
  // output register free this cycle
  assign out_load = (state == ST_SHOW) && (!m_tvalid || m_tready);

  always_comb begin
    div_start    = 1'b0;
    div_dividend = div_quot;
    st_we        = 1'b0;
    st_waddr     = count[AW-1:0];
    st_wdata     = div_rem;
    st_re        = 1'b0;
    st_raddr     = rd_idx;
    case (state)
      ST_IDLE: begin
        div_dividend = s_tdata[VALUE_BITS-1:0];
        if (accept) begin
          if (in_zero) begin
            // zero gives one digit '0'
            st_we    = 1'b1;
            st_waddr = '0;
            st_wdata = '0;
          end else begin
            div_start = 1'b1;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          st_we = 1'b1;
          if (div_quot != '0 && count != CNT_W'(MAX_DIGITS - 1)) begin
            div_start = 1'b1;
          end
        end
      end
      ST_READ: begin
        st_re = 1'b1;
      end
      ST_SHOW: begin
        // prefetch the next lower digit as the current one is shown
        if (out_load && rd_idx != '0) begin
          st_re    = 1'b1;
          st_raddr = rd_idx - 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (in_zero) begin
              count <= CNT_W'(1);
              state <= ST_READ;
            end else begin
              count <= '0;
              state <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          if (div_done) begin
            count <= count + 1'b1;
            if (!div_start) begin
              state <= ST_READ;
            end
          end
        end
        ST_READ: begin
          state <= ST_SHOW;
        end
        ST_SHOW: begin
          if (out_load && rd_idx == '0) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // readout index: starts at the most significant stored digit
  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      rd_idx <= '0;
    end else if (state == ST_DIV && div_done) begin
      rd_idx <= count[AW-1:0];
    end else if (out_load && rd_idx != '0) begin
      rd_idx <= rd_idx - 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_value <= st_rdata;
      out_last  <= (rd_idx == '0);
    end
  end

  assign m_tdata = {3'b000, digit_to_char(out_value), out_value};
  assign m_tlast = out_last;

  // ---------------------------------------------------------------------------
  // Datapath units
  // ---------------------------------------------------------------------------
  rdc_divider #(
    .VALUE_BITS (VALUE_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .base     (base),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  rdc_digit_store #(
    .DEPTH (MAX_DIGITS),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .re    (st_re),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

endmodule

`default_nettype wire

@@ rtl/rdc_checker.sv @@
// ============================================================================
// rdc_checker
// Port-level checks for the radix digit converter, bound to the top level.
// ============================================================================
`default_nettype none

module rdc_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [15:0]                    m_tdata,
  input logic                           m_tlast,
  input logic [rdc_pkg::CFG_DATA_W-1:0] prdata,
  input logic                           pready
);
  import rdc_pkg::*;

  logic [DIGIT_W-1:0] val;
  logic [CHAR_W-1:0]  chr;

  assign val = m_tdata[5:0];
  assign chr = m_tdata[12:6];

  // one number at a time: an accepted word closes the input
  a_in_close: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input open right after accept");

  // a waiting word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output word changed while stalled");

  // digit below the configured base
  a_digit_base: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> val < prdata[5:0])
    else $error("digit not below base");

  // character matches digit value
  a_char: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> chr == digit_to_char(val) && m_tdata[15:13] == 3'b000)
    else $error("digit character mismatch");

  // base register stays within 2..36
  a_base_range: assert property (@(posedge clk) disable iff (rst)
    pready && prdata[5:0] >= BASE_MIN && prdata[5:0] <= BASE_MAX)
    else $error("base out of range");

endmodule

bind radix_digit_converter rdc_checker u_rdc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .prdata   (prdata),
  .pready   (pready)
);

`default_nettype wire
